>>> rtl/ssi_pkg.sv
package ssi_pkg;

   // Sample, step and accumulator widths.
   localparam int SAMPLE_W = 32;
   localparam int SUM_W    = 48;
   localparam int N_W      = 54;
   localparam int STEP_W   = 31;
   localparam int COUNT_W  = 11;
   localparam int RES_W    = 64;

   // Widths of the scaling datapath: |n| * step split into two partial products.
   localparam int LO_W   = 32;
   localparam int PL_W   = LO_W + STEP_W;
   localparam int PH_W   = N_W - LO_W + STEP_W;
   localparam int P_W    = PH_W + LO_W + 1;
   localparam int SCALE_SHIFT = 18;
   localparam int X_W    = P_W - SCALE_SHIFT;

   // Division by three, one 16-bit digit per stage.
   localparam int DIG_W      = 16;
   localparam int NCH        = (X_W + DIG_W - 1) / DIG_W;
   localparam int QW         = NCH * DIG_W;
   localparam int CUR_W      = DIG_W + 2;
   localparam int PROD_W     = 2 * CUR_W;
   localparam int DIV3_SHIFT = CUR_W + 1;
   localparam logic [CUR_W-1:0] DIV3_RECIP = CUR_W'(174763);

   // Half of 12 * 65536, added before the divide for rounding.
   localparam logic [P_W-1:0] SCALE_HALF = P_W'(393216);

   // Pipeline lengths of the back end.
   localparam int LANE_LAT = 3 + NCH;
   localparam int LINE_LEN = 4 + LANE_LAT;

   // Job queue.
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;
   localparam int Q_CW    = 3;

   // Configuration register indexes.
   localparam logic [0:0] CSR_POINT_COUNT = 1'b0;
   localparam logic [0:0] CSR_STEP_WIDTH  = 1'b1;

   localparam logic [SAMPLE_W-1:0] STEP_RESET = 32'd65536;

   typedef enum logic [1:0] {
      JOB_ZERO,
      JOB_TWO,
      JOB_ODD,
      JOB_EVEN
   } job_kind_type;

   // One integration job handed from the front end to the back end.
   typedef struct packed {
      job_kind_type               kind;
      logic                       status;
      logic                       err_en;
      logic [STEP_W-1:0]          step;
      logic signed [SAMPLE_W-1:0] first;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] prev;
      logic signed [SAMPLE_W-1:0] older;
      logic signed [SUM_W-1:0]    even_sum;
      logic signed [SUM_W-1:0]    odd_sum;
   } job_type;

   // Control that travels beside the back-end datapath.
   typedef struct packed {
      logic valid;
      logic out_en;
      logic err_en;
      logic status;
   } ctl_type;

   function automatic logic signed [N_W-1:0] sx_sample(logic signed [SAMPLE_W-1:0] v);
      return {{(N_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
   endfunction

   function automatic logic signed [N_W-1:0] sx_sum(logic signed [SUM_W-1:0] v);
      return {{(N_W-SUM_W){v[SUM_W-1]}}, v};
   endfunction

endpackage

>>> rtl/ssi_front.sv
module ssi_front #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ssi_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                csr_write_enable,
   input  logic [0:0]                          csr_index,
   input  logic [ssi_pkg::SAMPLE_W-1:0]        csr_write_data,
   input  logic                                q_full,
   output logic                                q_push,
   output ssi_pkg::job_type                    q_job
);

   localparam int IDX_W = $clog2(MAX_POINTS + 1);

   logic [ssi_pkg::COUNT_W-1:0]         point_count_ff;
   logic [ssi_pkg::SAMPLE_W-1:0]        step_width_ff;
   logic signed [ssi_pkg::SUM_W-1:0]    even_sum_ff, even_sum_in;
   logic signed [ssi_pkg::SUM_W-1:0]    odd_sum_ff, odd_sum_in;
   logic signed [ssi_pkg::SAMPLE_W-1:0] first_ff, first_in;
   logic signed [ssi_pkg::SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [ssi_pkg::SAMPLE_W-1:0] older_ff, older_in;
   logic [IDX_W-1:0]                    point_index_ff, point_index_in;

   logic              accept;
   logic [31:0]       count32;
   logic [31:0]       k32;
   logic [IDX_W-1:0]  k;
   logic              short_run;
   logic              last_point;
   logic              step_pos;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
         step_width_ff  <= ssi_pkg::STEP_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            ssi_pkg::CSR_POINT_COUNT: point_count_ff <= csr_write_data[ssi_pkg::COUNT_W-1:0];
            ssi_pkg::CSR_STEP_WIDTH:  step_width_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Classify the item: short run, last point of a run, or interior point.
   always_comb begin
      count32    = 32'(point_count_ff);
      k          = point_index_ff + IDX_W'(1);
      k32        = 32'(k);
      short_run  = (count32 < 32'd2) || (count32 > 32'(MAX_POINTS));
      last_point = k32 >= count32;
      step_pos   = !step_width_ff[ssi_pkg::SAMPLE_W-1] && (step_width_ff != '0);
   end

   // Build the job that goes to the back end.
   always_comb begin
      if (short_run) begin
         q_job.kind = ssi_pkg::JOB_ZERO;
      end else if (k32 == 32'd2) begin
         q_job.kind = ssi_pkg::JOB_TWO;
      end else if (k[0]) begin
         q_job.kind = ssi_pkg::JOB_ODD;
      end else begin
         q_job.kind = ssi_pkg::JOB_EVEN;
      end
      q_job.status   = !short_run && !step_pos;
      q_job.err_en   = k32 > 32'd4;
      q_job.step     = step_width_ff[ssi_pkg::STEP_W-1:0];
      q_job.first    = first_ff;
      q_job.sample   = req_sample;
      q_job.prev     = prev_ff;
      q_job.older    = older_ff;
      q_job.even_sum = even_sum_ff;
      q_job.odd_sum  = odd_sum_ff;
   end

   // Run state update: accumulate interior points, clear at the end of a run.
   always_comb begin
      q_push         = 1'b0;
      even_sum_in    = even_sum_ff;
      odd_sum_in     = odd_sum_ff;
      first_in       = first_ff;
      prev_in        = prev_ff;
      older_in       = older_ff;
      point_index_in = point_index_ff;
      if (accept) begin
         if (short_run || last_point) begin
            q_push         = 1'b1;
            even_sum_in    = '0;
            odd_sum_in     = '0;
            first_in       = '0;
            prev_in        = '0;
            older_in       = '0;
            point_index_in = '0;
         end else begin
            if (k32 == 32'd1) begin
               first_in = req_sample;
            end else if (!k[0]) begin
               even_sum_in = even_sum_ff + ssi_pkg::SUM_W'(req_sample);
            end else begin
               odd_sum_in = odd_sum_ff + ssi_pkg::SUM_W'(req_sample);
            end
            older_in       = prev_ff;
            prev_in        = req_sample;
            point_index_in = k;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         even_sum_ff    <= '0;
         odd_sum_ff     <= '0;
         first_ff       <= '0;
         prev_ff        <= '0;
         older_ff       <= '0;
         point_index_ff <= '0;
      end else begin
         even_sum_ff    <= even_sum_in;
         odd_sum_ff     <= odd_sum_in;
         first_ff       <= first_in;
         prev_ff        <= prev_in;
         older_ff       <= older_in;
         point_index_ff <= point_index_in;
      end
   end

endmodule

>>> rtl/ssi_queue.sv
module ssi_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ssi_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             nonempty,
   output ssi_pkg::job_type head_job
);

   ssi_pkg::job_type               entry_ff [ssi_pkg::Q_DEPTH];
   logic [ssi_pkg::Q_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ssi_pkg::Q_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ssi_pkg::Q_CW-1:0]       count_ff, count_in;
   logic                           do_push, do_pop;

   assign full     = count_ff == ssi_pkg::Q_CW'(ssi_pkg::Q_DEPTH);
   assign nonempty = count_ff != '0;
   assign head_job = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && nonempty;

   // Pointer and fill count bookkeeping.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + ssi_pkg::Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + ssi_pkg::Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + ssi_pkg::Q_CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - ssi_pkg::Q_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/ssi_scale.sv
module ssi_scale (
   input  logic                              clock,
   input  logic                              enable,
   input  logic signed [ssi_pkg::N_W-1:0]    n_in,
   input  logic [ssi_pkg::STEP_W-1:0]        step_in,
   output logic signed [ssi_pkg::RES_W-1:0]  result
);

   localparam int LAT = ssi_pkg::LANE_LAT;

   logic [ssi_pkg::N_W-1:0]    n_bits;
   logic [ssi_pkg::N_W-1:0]    mag_in, mag_ff;
   logic [ssi_pkg::STEP_W-1:0] step_ff;
   logic [ssi_pkg::PL_W-1:0]   pl_ff;
   logic [ssi_pkg::PH_W-1:0]   ph_ff;
   logic [ssi_pkg::P_W-1:0]    prod_sum;
   logic [ssi_pkg::QW-1:0]     x_ff;
   logic                       neg_ff [LAT];

   logic [ssi_pkg::QW-1:0]     word_src [ssi_pkg::NCH];
   logic [1:0]                 rem_src  [ssi_pkg::NCH];
   logic [ssi_pkg::QW-1:0]     word_ff  [ssi_pkg::NCH];
   logic [1:0]                 rem_ff   [ssi_pkg::NCH];

   logic [ssi_pkg::QW-1:0]     q_final;
   logic                       over;
   logic [ssi_pkg::RES_W-1:0]  q_low;

   // Magnitude of the weighted sum.
   assign n_bits = n_in;
   assign mag_in = n_in[ssi_pkg::N_W-1] ? (~n_bits + ssi_pkg::N_W'(1)) : n_bits;

   // The sign rides along the whole lane.
   always_ff @(posedge clock) begin
      if (enable) begin
         neg_ff[0] <= n_in[ssi_pkg::N_W-1];
         for (int i = 1; i < LAT; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
      end
   end

   // Stage 1: magnitude and step. Stage 2: two partial products.
   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff  <= mag_in;
         step_ff <= step_in;
         pl_ff   <= ssi_pkg::PL_W'(mag_ff[ssi_pkg::LO_W-1:0]) * ssi_pkg::PL_W'(step_ff);
         ph_ff   <= ssi_pkg::PH_W'(mag_ff[ssi_pkg::N_W-1:ssi_pkg::LO_W])
                    * ssi_pkg::PH_W'(step_ff);
      end
   end

   // Stage 3: full product plus rounding half, then drop the power-of-two part.
   assign prod_sum = ssi_pkg::P_W'(pl_ff) + {1'b0, ph_ff, {ssi_pkg::LO_W{1'b0}}}
                     + ssi_pkg::SCALE_HALF;

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= ssi_pkg::QW'(prod_sum[ssi_pkg::P_W-1:ssi_pkg::SCALE_SHIFT]);
      end
   end

   // Long division by three, most significant digit first, one digit per stage.
   // Each stage replaces its digit of the word with the quotient digit.
   for (genvar j = 0; j < ssi_pkg::NCH; j++) begin : g_div
      localparam int LSB = (ssi_pkg::NCH - 1 - j) * ssi_pkg::DIG_W;

      logic [ssi_pkg::CUR_W-1:0]  cur;
      logic [ssi_pkg::PROD_W-1:0] recip_prod;
      logic [ssi_pkg::DIG_W-1:0]  q_digit;
      logic [ssi_pkg::CUR_W-1:0]  rem_wide;
      logic [ssi_pkg::QW-1:0]     word_next;

      if (j == 0) begin : g_first
         assign word_src[j] = x_ff;
         assign rem_src[j]  = 2'b00;
      end else begin : g_next
         assign word_src[j] = word_ff[j-1];
         assign rem_src[j]  = rem_ff[j-1];
      end

      always_comb begin
         cur        = {rem_src[j], word_src[j][LSB +: ssi_pkg::DIG_W]};
         recip_prod = ssi_pkg::PROD_W'(cur) * ssi_pkg::PROD_W'(ssi_pkg::DIV3_RECIP);
         q_digit    = recip_prod[ssi_pkg::DIV3_SHIFT +: ssi_pkg::DIG_W];
         rem_wide   = cur - {q_digit, 1'b0} - ssi_pkg::CUR_W'(q_digit);
         word_next  = word_src[j];
         word_next[LSB +: ssi_pkg::DIG_W] = q_digit;
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            word_ff[j] <= word_next;
            rem_ff[j]  <= rem_wide[1:0];
         end
      end
   end

   // Apply the sign and saturate to 64 bits.
   assign q_final = word_ff[ssi_pkg::NCH-1];
   assign over    = |q_final[ssi_pkg::QW-1:ssi_pkg::RES_W-1];
   assign q_low   = q_final[ssi_pkg::RES_W-1:0];

   always_comb begin
      if (!neg_ff[LAT-1]) begin
         result = over ? {1'b0, {(ssi_pkg::RES_W-1){1'b1}}} : q_low;
      end else begin
         result = over ? {1'b1, {(ssi_pkg::RES_W-1){1'b0}}} : (~q_low + ssi_pkg::RES_W'(1));
      end
   end

endmodule

>>> rtl/ssi_back.sv
module ssi_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  ssi_pkg::job_type                  q_job,
   output logic                              q_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ssi_pkg::RES_W-1:0]  rsp_integral,
   output logic signed [ssi_pkg::RES_W-1:0]  rsp_error_estimate,
   output logic                              rsp_status
);

   localparam int LINE = ssi_pkg::LINE_LEN;

   logic                 adv;
   ssi_pkg::ctl_type     ctl_in;
   ssi_pkg::ctl_type     ctl_ff [LINE];
   ssi_pkg::ctl_type     ctl_out;

   logic signed [ssi_pkg::N_W-1:0] sf, ss, sp, so, se, sd;

   // Stage B1 terms.
   ssi_pkg::job_kind_type           kind_b1_ff, kind_b2_ff;
   logic signed [ssi_pkg::N_W-1:0]  fs_b1_ff, fa_b1_ff, sb_b1_ff, cor_b1_ff, s_b1_ff;
   // Stage B2 and B3 terms.
   logic signed [ssi_pkg::N_W-1:0]  ns_b2_ff, t_b2_ff, ns_b3_ff, nt_b3_ff;
   logic signed [ssi_pkg::N_W-1:0]  ns_b4_ff, d_b4_ff;
   logic signed [ssi_pkg::N_W-1:0]  ns_b2_in, nt_b3_in;
   logic [ssi_pkg::STEP_W-1:0]      step_b1_ff, step_b2_ff, step_b3_ff, step_b4_ff;

   logic signed [ssi_pkg::RES_W-1:0] lane_integral, lane_error;

   logic                             rsp_valid_ff;
   logic signed [ssi_pkg::RES_W-1:0] rsp_integral_ff, rsp_error_ff;
   logic                             rsp_status_ff;

   // The whole back pipeline moves together unless a held result is stalled.
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && q_valid;

   always_comb begin
      ctl_in.valid  = q_pop;
      ctl_in.out_en = (q_job.kind != ssi_pkg::JOB_ZERO) && !q_job.status;
      ctl_in.err_en = q_job.err_en;
      ctl_in.status = q_job.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (adv) begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < LINE; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // B1: partial sums of the weighted Simpson and trapezoid terms.
   assign sf = ssi_pkg::sx_sample(q_job.first);
   assign ss = ssi_pkg::sx_sample(q_job.sample);
   assign sp = ssi_pkg::sx_sample(q_job.prev);
   assign so = ssi_pkg::sx_sample(q_job.older);
   assign se = ssi_pkg::sx_sum(q_job.even_sum);
   assign sd = ssi_pkg::sx_sum(q_job.odd_sum);

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_b1_ff <= q_job.kind;
         step_b1_ff <= q_job.step;
         fs_b1_ff   <= sf + ss;
         fa_b1_ff   <= sf + (se <<< 2) + (sd <<< 1);
         sb_b1_ff   <= (se + sd) <<< 1;
         cor_b1_ff  <= (sp <<< 2) + (ss <<< 2) + ss - so;
         s_b1_ff    <= ss;
      end
   end

   // B2: the Simpson sum in twelfths, by the shape of the run.
   always_comb begin
      case (kind_b1_ff)
         ssi_pkg::JOB_TWO:  ns_b2_in = (fs_b1_ff <<< 2) + (fs_b1_ff <<< 1);
         ssi_pkg::JOB_ODD:  ns_b2_in = (fa_b1_ff + s_b1_ff) <<< 2;
         ssi_pkg::JOB_EVEN: ns_b2_in = (fa_b1_ff <<< 2) + cor_b1_ff;
         default:           ns_b2_in = '0;
      endcase
   end

   // B3: the trapezoid sum in twelfths; for two points it equals Simpson.
   assign nt_b3_in = (kind_b2_ff == ssi_pkg::JOB_TWO) ? ns_b2_ff
                                                      : (t_b2_ff <<< 2) + (t_b2_ff <<< 1);

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_b2_ff <= kind_b1_ff;
         step_b2_ff <= step_b1_ff;
         ns_b2_ff   <= ns_b2_in;
         t_b2_ff    <= fs_b1_ff + sb_b1_ff;
         step_b3_ff <= step_b2_ff;
         ns_b3_ff   <= ns_b2_ff;
         nt_b3_ff   <= nt_b3_in;
         step_b4_ff <= step_b3_ff;
         ns_b4_ff   <= ns_b3_ff;
         d_b4_ff    <= ns_b3_ff - nt_b3_ff;
      end
   end

   // Two scaling lanes: the integral and the Simpson minus trapezoid difference.
   ssi_scale u_scale_integral (
      .clock   (clock),
      .enable  (adv),
      .n_in    (ns_b4_ff),
      .step_in (step_b4_ff),
      .result  (lane_integral)
   );

   ssi_scale u_scale_error (
      .clock   (clock),
      .enable  (adv),
      .n_in    (d_b4_ff),
      .step_in (step_b4_ff),
      .result  (lane_error)
   );

   // Output register; it holds while the consumer stalls.
   assign ctl_out = ctl_ff[LINE-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= ctl_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_integral_ff <= ctl_out.out_en ? lane_integral : '0;
         rsp_error_ff    <= (ctl_out.out_en && ctl_out.err_en) ? lane_error : '0;
         rsp_status_ff   <= ctl_out.status;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_integral       = rsp_integral_ff;
   assign rsp_error_estimate = rsp_error_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

>>> rtl/simpson_stream_integrator_top.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_sample (s32 Q16.16)
// rsp_      out        rsp_valid/rsp_stall   rsp_integral, rsp_error_estimate (s64), rsp_status
// csr_      in         csr_write_enable      csr_index (0 point_count, 1 step_width), csr_write_data
//
// One sample is accepted every cycle while req_stall is low.
// The result of a run reaches the output register through the job queue, the staging
// registers B1 to B4 that form the weighted sums, the magnitude, partial-product and
// rounding registers, and the divide-by-three digit registers.
// Reset is synchronous; there is no clearing pass.
// A stalled result freezes the back pipeline; the four-entry job queue absorbs finished
// runs, and req_stall rises only when that queue is full.
module simpson_stream_integrator_top #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [ssi_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ssi_pkg::RES_W-1:0]    rsp_integral,
   output logic signed [ssi_pkg::RES_W-1:0]    rsp_error_estimate,
   output logic                                rsp_status,
   input  logic                                csr_write_enable,
   input  logic [0:0]                          csr_index,
   input  logic [ssi_pkg::SAMPLE_W-1:0]        csr_write_data
);

   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_nonempty;
   ssi_pkg::job_type push_job;
   ssi_pkg::job_type head_job;

   // Front end: run bookkeeping and job creation.
   ssi_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_job            (push_job)
   );

   // Job queue between the two halves.
   ssi_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .nonempty (q_nonempty),
      .head_job (head_job)
   );

   // Back end: weighted sums, scaling, rounding and saturation.
   ssi_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_nonempty),
      .q_job              (head_job),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_integral       (rsp_integral),
      .rsp_error_estimate (rsp_error_estimate),
      .rsp_status         (rsp_status)
   );

endmodule

>>> dv/simpson_stream_integrator_checker.sv
`timescale 1ns / 1ps

module simpson_stream_integrator_checker #(
   parameter int MAX_POINTS = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic signed [ssi_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic signed [ssi_pkg::RES_W-1:0]    rsp_integral,
   input  logic signed [ssi_pkg::RES_W-1:0]    rsp_error_estimate,
   input  logic                                rsp_status,
   input  logic                                csr_write_enable,
   input  logic [0:0]                          csr_index,
   input  logic [ssi_pkg::SAMPLE_W-1:0]        csr_write_data,
   output int                                  fail_count,
   output int                                  pending
);

   // Value = N * step / (12 * 65536), N being the weighted sum in twelfths.
   localparam logic [127:0] SCALE_DIVISOR = 128'd786432;
   localparam logic [127:0] SCALE_ROUND   = 128'd393216;
   localparam logic [127:0] POS_LIMIT     = 128'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]  SAT_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0]  SAT_MIN       = 64'h8000_0000_0000_0000;
   localparam logic         STATUS_OK       = 1'b0;
   localparam logic         STATUS_BAD_STEP = 1'b1;
   localparam int           RESET_COUNT     = 0;

   typedef struct packed {
      logic signed [63:0] integral;
      logic signed [63:0] error_estimate;
      logic               status;
   } integral_result_type;

   integral_result_type expected_integrals[$];

   // Copy of the configuration and of the running-sum state.
   logic [ssi_pkg::COUNT_W-1:0] cfg_count;
   logic signed [31:0]          cfg_step;
   longint                      even_acc;
   longint                      odd_acc;
   longint                      first_smp;
   longint                      prev_smp;
   longint                      older_smp;
   int unsigned                 taken;
   int                          mismatches;

   // Round to nearest with ties away from zero, then saturate to 64 bits.
   function automatic logic signed [63:0] scale_to_q16(longint n, logic [31:0] step);
      logic         neg;
      logic [127:0] mag;
      logic [127:0] quo;
      neg = (n < 0);
      mag = 128'(neg ? -n : n);
      quo = (mag * {96'd0, step} + SCALE_ROUND) / SCALE_DIVISOR;
      if (!neg) begin
         return (quo > POS_LIMIT) ? SAT_MAX : quo[63:0];
      end
      if (quo > POS_LIMIT) begin
         return SAT_MIN;
      end
      return -$signed(quo[63:0]);
   endfunction

   function automatic void clear_run();
      even_acc  = 0;
      odd_acc   = 0;
      first_smp = 0;
      prev_smp  = 0;
      older_smp = 0;
      taken     = 0;
   endfunction

   // Fold one accepted sample into the run; queue a result when the run ends.
   function automatic void integrate_sample(logic signed [31:0] s);
      longint              sv;
      longint              ns;
      longint              nt;
      longint              odd_in;
      int unsigned         k;
      integral_result_type res;
      sv  = longint'(s);
      res = '0;
      // A count below two or above the maximum gives zero for every sample.
      if (cfg_count < 2 || cfg_count > MAX_POINTS) begin
         clear_run();
         res.status = STATUS_OK;
         expected_integrals.push_back(res);
         return;
      end
      k = taken + 1;
      if (k < cfg_count) begin
         if (k == 1) begin
            first_smp = sv;
         end else if (k[0] == 1'b0) begin
            even_acc += sv;
         end else begin
            odd_acc += sv;
         end
         older_smp = prev_smp;
         prev_smp  = sv;
         taken     = k;
         return;
      end
      // Final sample: trapezoid, odd-count Simpson or Simpson with end correction.
      if (k == 2) begin
         ns = 6 * (first_smp + sv);
         nt = ns;
      end else if (k[0] == 1'b1) begin
         ns = 4 * (first_smp + 4 * even_acc + 2 * odd_acc + sv);
         nt = 6 * (first_smp + 2 * (even_acc + odd_acc) + sv);
      end else begin
         odd_in = odd_acc - prev_smp;
         ns = 4 * (first_smp + 4 * even_acc + 2 * odd_in + prev_smp)
            + (8 * prev_smp + 5 * sv - older_smp);
         nt = 6 * (first_smp + 2 * (even_acc + odd_acc) + sv);
      end
      if (cfg_step <= 0) begin
         res.status = STATUS_BAD_STEP;
      end else begin
         res.status   = STATUS_OK;
         res.integral = scale_to_q16(ns, cfg_step);
         if (k > 4) begin
            res.error_estimate = scale_to_q16(ns - nt, cfg_step);
         end
      end
      clear_run();
      expected_integrals.push_back(res);
   endfunction

   // Compare one accepted result with the oldest expectation.
   function automatic void check_result();
      integral_result_type want;
      if (expected_integrals.size() == 0) begin
         $display("%0t: unexpected result, actual integral %0d error %0d status %0d",
                  $time, rsp_integral, rsp_error_estimate, rsp_status);
         mismatches++;
         return;
      end
      want = expected_integrals.pop_front();
      if (rsp_integral !== want.integral) begin
         $display("%0t: integral mismatch, expected %0d, actual %0d",
                  $time, want.integral, rsp_integral);
         mismatches++;
      end
      if (rsp_error_estimate !== want.error_estimate) begin
         $display("%0t: error_estimate mismatch, expected %0d, actual %0d",
                  $time, want.error_estimate, rsp_error_estimate);
         mismatches++;
      end
      if (rsp_status !== want.status) begin
         $display("%0t: status mismatch, expected %0d, actual %0d",
                  $time, want.status, rsp_status);
         mismatches++;
      end
   endfunction

   // Watch the channels at every edge; the values seen are those before the edge.
   always @(posedge clock) begin
      if (reset) begin
         cfg_count  = ssi_pkg::COUNT_W'(RESET_COUNT);
         cfg_step   = ssi_pkg::STEP_RESET;
         mismatches = 0;
         clear_run();
         expected_integrals.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result();
         end
         if (req_valid && !req_stall) begin
            integrate_sample(req_sample);
         end
         if (csr_write_enable) begin
            if (csr_index == ssi_pkg::CSR_POINT_COUNT) begin
               cfg_count = csr_write_data[ssi_pkg::COUNT_W-1:0];
            end else begin
               cfg_step = csr_write_data;
            end
         end
      end
      fail_count <= mismatches;
      pending    <= expected_integrals.size();
   end

endmodule

>>> dv/simpson_stream_integrator_top_tb.sv
`timescale 1ns / 1ps

module simpson_stream_integrator_top_tb;

   localparam int MAX_POINTS     = 1024;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int LATENCY_PAUSE  = 24;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 4000;

   logic                                clock              = 1'b0;
   logic                                reset              = 1'b1;
   logic                                req_valid          = 1'b0;
   logic                                req_stall;
   logic signed [ssi_pkg::SAMPLE_W-1:0] req_sample         = '0;
   logic                                rsp_valid;
   logic                                rsp_stall          = 1'b0;
   logic signed [ssi_pkg::RES_W-1:0]    rsp_integral;
   logic signed [ssi_pkg::RES_W-1:0]    rsp_error_estimate;
   logic                                rsp_status;
   logic                                csr_write_enable   = 1'b0;
   logic [0:0]                          csr_index          = ssi_pkg::CSR_POINT_COUNT;
   logic [ssi_pkg::SAMPLE_W-1:0]        csr_write_data     = '0;

   int mismatch_count;
   int pending_results;
   int quiet_cycles = 0;
   bit hold_request = 1'b0;
   bit full_run_done = 1'b0;

   always #10 clock = ~clock;

   simpson_stream_integrator_top #(
      .MAX_POINTS(MAX_POINTS)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_integral      (rsp_integral),
      .rsp_error_estimate(rsp_error_estimate),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   simpson_stream_integrator_checker #(
      .MAX_POINTS(MAX_POINTS)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_integral      (rsp_integral),
      .rsp_error_estimate(rsp_error_estimate),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .fail_count        (mismatch_count),
      .pending           (pending_results)
   );

   // Mostly full-range samples, some small signed values and some extremes.
   function automatic logic signed [31:0] draw_sample();
      int v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
         1, 2: begin
            v = int'($urandom_range(0, 2097152)) - 1048576;
            return v;
         end
         default: return $urandom;
      endcase
   endfunction

   // Step widths, including zero, negative values and both extremes.
   function automatic logic signed [31:0] draw_step();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : ($urandom | 32'h8000_0000);
         2: return 32'h7FFF_FFFF;
         3: return 32'h0000_0001;
         4, 5: return ssi_pkg::STEP_RESET;
         default: return $urandom_range(1, 32'h7FFF_FFFF);
      endcase
   endfunction

   // Point counts: mostly short runs, a few medium, and the edges of the range.
   function automatic int draw_count();
      case ($urandom_range(0, 19))
         0: return 0;
         1: return 1;
         2: return $urandom_range(MAX_POINTS + 1, 2047);
         3: begin
            if (!full_run_done) begin
               full_run_done = 1'b1;
               return MAX_POINTS;
            end
            return $urandom_range(2, 12);
         end
         4, 5, 6: return $urandom_range(13, 64);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   task automatic write_csr(input logic [0:0] idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int count, input logic signed [31:0] step);
      write_csr(ssi_pkg::CSR_POINT_COUNT, 32'(count));
      write_csr(ssi_pkg::CSR_STEP_WIDTH, step);
   endtask

   // Offer one item after a random gap and hold it until it is taken.
   task automatic send_sample(input logic signed [31:0] s, input bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
   endtask

   // Wait until every expected result has come, then let the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (LATENCY_PAUSE) @(posedge clock);
   endtask

   // Result side: a random stall before each item, one long hold on request.
   initial begin
      int  wait_n;
      int  since_mode;
      bit  eager;
      since_mode = 0;
      eager      = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            wait_n = eager ? 0 : $urandom_range(0, 5);
            if (wait_n > 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         since_mode++;
         if (since_mode >= 32) begin
            since_mode = 0;
            eager      = ($urandom_range(0, 3) == 0);
         end
      end
   end

   // A run with nothing accepted for too long means the block is stuck.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("** simpson_stream_integrator_top: FAILED **");
            $finish;
         end
      end
   end

   // Stimulus: directed runs, then random phases, then the verdict.
   initial begin
      int  count;
      int  n_items;
      int  runs;
      int  sent_random;
      int  phase;
      bit  no_gaps;
      logic signed [31:0] step;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Count left at zero after reset, then a count of one: zero results.
      send_sample(32'h7FFF_FFFF, 1'b0);
      settle();
      configure(1, ssi_pkg::STEP_RESET);
      send_sample(32'h8000_0000, 1'b0);
      settle();

      // Two points take the trapezoid rule.
      configure(2, ssi_pkg::STEP_RESET);
      send_sample(32'h7FFF_FFFF, 1'b0);
      send_sample(32'h7FFF_FFFF, 1'b1);
      settle();

      // Three points at the widest step.
      configure(3, 32'h7FFF_FFFF);
      repeat (3) send_sample(32'h8000_0000, 1'b1);
      settle();

      // Five points give an error estimate; six points at a negative step end with the error status.
      configure(5, ssi_pkg::STEP_RESET);
      repeat (5) send_sample(draw_sample(), 1'b0);
      settle();
      configure(6, 32'h8000_0000);
      repeat (6) send_sample(draw_sample(), 1'b0);
      settle();

      // Zero step: the run ends with the error status.
      configure(2, 32'h0000_0000);
      repeat (2) send_sample(draw_sample(), 1'b0);
      settle();

      // Count lowered in the middle of a run: it ends at four points.
      configure(6, 32'h0000_0001);
      repeat (3) send_sample(draw_sample(), 1'b0);
      settle();
      write_csr(ssi_pkg::CSR_POINT_COUNT, 32'd4);
      send_sample(draw_sample(), 1'b0);
      settle();

      // Random phases; the first one runs under a long result hold-off.
      sent_random = 0;
      phase       = 0;
      while (sent_random < RANDOM_ITEMS) begin
         count   = (phase == 0) ? 2 : draw_count();
         step    = draw_step();
         no_gaps = ($urandom_range(0, 3) == 0);
         configure(count, step);
         if (count < 2 || count > MAX_POINTS) begin
            n_items = $urandom_range(4, 12);
         end else begin
            if (phase == 0) begin
               runs = 40;
            end else if (count == MAX_POINTS) begin
               runs = 1;
            end else if (count <= 12) begin
               runs = $urandom_range(3, 10);
            end else begin
               runs = $urandom_range(1, 3);
            end
            n_items = runs * count;
            // Sometimes leave a run open so the next phase picks it up.
            if (count < MAX_POINTS && $urandom_range(0, 3) == 0) begin
               n_items += $urandom_range(1, count - 1);
            end
         end
         if (phase == 0) begin
            hold_request = 1'b1;
         end
         repeat (n_items) begin
            send_sample(draw_sample(), no_gaps);
            sent_random++;
         end
         settle();
         phase++;
      end

      if (mismatch_count == 0) begin
         $display("** simpson_stream_integrator_top: PASSED **");
      end else begin
         $display("** simpson_stream_integrator_top: FAILED **");
      end
      $finish;
   end

endmodule
